// ===== hw/rtl/complex_arith_unit_top_assert.svh =====
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CAU_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// two expressions agree in every cycle
`define CAU_ASSERT_SAME(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) == (rhs)) \
      else $error(msg);

`endif

// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

   localparam int FRAC_BITS = 16;

   localparam logic [2:0] KIND_ADD  = 3'd0;
   localparam logic [2:0] KIND_SUB  = 3'd1;
   localparam logic [2:0] KIND_MUL  = 3'd2;
   localparam logic [2:0] KIND_DIV  = 3'd3;
   localparam logic [2:0] KIND_SQRT = 3'd4;
   localparam logic [2:0] KIND_MOD  = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   localparam int ISQRT_STEPS  = 32;
   localparam int ISQRT_LAT    = ISQRT_STEPS + 2;
   localparam int DIV_QBITS    = 33;
   localparam int DIV_NUM_W    = 64 + FRAC_BITS + 1;
   localparam int DIV_HI_W     = DIV_NUM_W - DIV_QBITS;
   localparam int DIV_LAT      = DIV_QBITS + 1;
   localparam int FRONT_STAGES = 3;
   localparam int RSP_LATENCY  = FRONT_STAGES + 2 * ISQRT_LAT + 1;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] a_real;
      logic signed [31:0] a_imag;
      logic signed [31:0] b_real;
      logic signed [31:0] b_imag;
   } cau_req_type;

   typedef struct packed {
      logic signed [31:0] res_real;
      logic signed [31:0] res_imag;
      logic [1:0]         status;
   } cau_rsp_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] value;
   } cau_fix_type;

   function automatic cau_fix_type to_fixed(input logic neg, input logic [63:0] mag);
      cau_fix_type f;
      f.sat   = 1'b0;
      f.value = mag[31:0];
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) begin
            f.sat   = 1'b1;
            f.value = 32'h8000_0000;
         end else begin
            f.value = ~mag[31:0] + 32'd1;
         end
      end else if (mag > 64'h0000_0000_7FFF_FFFF) begin
         f.sat   = 1'b1;
         f.value = 32'h7FFF_FFFF;
      end
      return f;
   endfunction

endpackage

// ===== hw/rtl/cau_isqrt.sv =====
module cau_isqrt
   import cau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_radicand,
   output logic        out_valid,
   output logic [32:0] out_root
);

   logic [63:0] rem_ff   [0:ISQRT_STEPS];
   logic [63:0] root_ff  [0:ISQRT_STEPS];
   logic        valid_ff [0:ISQRT_STEPS];
   logic [63:0] rem_in   [0:ISQRT_STEPS];
   logic [63:0] root_in  [0:ISQRT_STEPS];
   logic        out_valid_ff;
   logic [32:0] out_root_ff;
   logic [32:0] out_root_in;

   assign rem_in[0]  = in_radicand;
   assign root_in[0] = '0;

   genvar k;
   for (k = 0; k < ISQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] STEP_BIT = 64'd1 << (2 * ISQRT_STEPS - 2 - 2 * k);
      logic [63:0] trial;
      logic        take;
      assign trial        = root_ff[k] + STEP_BIT;
      assign take         = rem_ff[k] >= trial;
      assign rem_in[k+1]  = take ? rem_ff[k] - trial : rem_ff[k];
      assign root_in[k+1] = take ? (root_ff[k] >> 1) + STEP_BIT : root_ff[k] >> 1;
   end

   assign out_root_in = (rem_ff[ISQRT_STEPS] > root_ff[ISQRT_STEPS])
                      ? root_ff[ISQRT_STEPS][32:0] + 33'd1
                      : root_ff[ISQRT_STEPS][32:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ISQRT_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= ISQRT_STEPS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         out_valid_ff <= valid_ff[ISQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= ISQRT_STEPS; i++) begin
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
      end
      out_root_ff <= out_root_in;
   end

   assign out_valid = out_valid_ff;
   assign out_root  = out_root_ff;

endmodule

// ===== hw/rtl/cau_div.sv =====
module cau_div
   import cau_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [63:0]          in_num,
   input  logic [63:0]          in_den,
   output logic                 out_valid,
   output logic [DIV_QBITS-1:0] out_quot,
   output logic                 out_ovf
);

   logic [63:0]          rem_ff   [0:DIV_QBITS];
   logic [DIV_QBITS-1:0] low_ff   [0:DIV_QBITS];
   logic [63:0]          den_ff   [0:DIV_QBITS];
   logic [DIV_QBITS-1:0] quot_ff  [0:DIV_QBITS];
   logic                 ovf_ff   [0:DIV_QBITS];
   logic                 valid_ff [0:DIV_QBITS];
   logic [63:0]          rem_in   [0:DIV_QBITS];
   logic [DIV_QBITS-1:0] quot_in  [0:DIV_QBITS];
   logic [DIV_NUM_W-1:0] num_wide;
   logic [DIV_HI_W-1:0]  num_hi;

   assign num_wide   = {in_num, {(FRAC_BITS + 1){1'b0}}};
   assign num_hi     = num_wide[DIV_NUM_W-1:DIV_QBITS];
   assign rem_in[0]  = 64'(num_hi);
   assign quot_in[0] = '0;

   genvar k;
   for (k = 0; k < DIV_QBITS; k++) begin : g_step
      logic [64:0] trial;
      logic [64:0] diff;
      logic        ge;
      assign trial        = {rem_ff[k], low_ff[k][DIV_QBITS-1-k]};
      assign diff         = trial - {1'b0, den_ff[k]};
      assign ge           = trial >= {1'b0, den_ff[k]};
      assign rem_in[k+1]  = ge ? diff[63:0] : trial[63:0];
      assign quot_in[k+1] = {quot_ff[k][DIV_QBITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_QBITS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= DIV_QBITS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff[0] <= num_wide[DIV_QBITS-1:0];
      den_ff[0] <= in_den;
      ovf_ff[0] <= 64'(num_hi) >= in_den;
      for (int i = 0; i <= DIV_QBITS; i++) begin
         rem_ff[i]  <= rem_in[i];
         quot_ff[i] <= quot_in[i];
      end
      for (int i = 1; i <= DIV_QBITS; i++) begin
         low_ff[i] <= low_ff[i-1];
         den_ff[i] <= den_ff[i-1];
         ovf_ff[i] <= ovf_ff[i-1];
      end
   end

   assign out_valid = valid_ff[DIV_QBITS];
   assign out_quot  = quot_ff[DIV_QBITS];
   assign out_ovf   = ovf_ff[DIV_QBITS];

endmodule

// ===== hw/rtl/complex_arith_unit_top.sv =====
// The result strobe rises once a transaction has passed the operand, product and sum stages, both side
// lines and the result register; one transaction per cycle, back to back.
// Depth is set by two chained 32-step square root pipelines (modulus, then the root parts);
// the two 33-step dividers run alongside the first one.
// busy is high only while reset is asserted; the result side cannot stall.
// Reset is synchronous, active high, and clears every valid bit in flight.
`include "complex_arith_unit_top_assert.svh"

module complex_arith_unit_top
   import cau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  cau_req_type req_data,
   output logic        rsp_strobe,
   output cau_rsp_type rsp_data
);

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] res_real;
      logic signed [31:0] res_imag;
      logic               sat;
      logic               dz;
      logic               re_neg;
      logic               im_neg;
      logic signed [31:0] a_real;
      logic               a_neg;
   } side_type;

   localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] DIV_BIG    = 64'd1 << DIV_QBITS;

   assign busy = reset;

   // operand stage
   logic        op_valid_ff;
   cau_req_type op_ff;
   cau_req_type op_in;

   always_comb begin
      op_in = req_data;
      if (req_data.kind == KIND_SQRT || req_data.kind == KIND_MOD) begin
         op_in.b_real = req_data.a_real;
         op_in.b_imag = req_data.a_imag;
      end
   end

   // product stage
   logic               prod_valid_ff;
   logic [2:0]         prod_kind_ff;
   logic signed [31:0] prod_ar_ff;
   logic signed [31:0] prod_ai_ff;
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [63:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_bb_in, p_cc_in;
   logic [32:0]        as_re_ff, as_im_ff;
   logic [32:0]        as_re_in, as_im_in;

   always_comb begin
      p_rr_in = op_ff.a_real * op_ff.b_real;
      p_ii_in = op_ff.a_imag * op_ff.b_imag;
      p_ri_in = op_ff.a_real * op_ff.b_imag;
      p_ir_in = op_ff.a_imag * op_ff.b_real;
      p_bb_in = op_ff.b_real * op_ff.b_real;
      p_cc_in = op_ff.b_imag * op_ff.b_imag;
      if (op_ff.kind == KIND_SUB) begin
         as_re_in = {op_ff.a_real[31], op_ff.a_real} - {op_ff.b_real[31], op_ff.b_real};
         as_im_in = {op_ff.a_imag[31], op_ff.a_imag} - {op_ff.b_imag[31], op_ff.b_imag};
      end else begin
         as_re_in = {op_ff.a_real[31], op_ff.a_real} + {op_ff.b_real[31], op_ff.b_real};
         as_im_in = {op_ff.a_imag[31], op_ff.a_imag} + {op_ff.b_imag[31], op_ff.b_imag};
      end
   end

   // sum stage
   logic               sum_valid_ff;
   logic [2:0]         sum_kind_ff;
   logic signed [31:0] sum_ar_ff;
   logic signed [31:0] sum_ai_ff;
   logic               re_neg_ff, im_neg_ff, re_neg_in, im_neg_in;
   logic [63:0]        re_mag_ff, im_mag_ff, re_mag_in, im_mag_in;
   logic [63:0]        den_ff, den_in;
   logic [31:0]        as_re_sat_ff, as_im_sat_ff, as_re_sat_in, as_im_sat_in;
   logic               as_sat_ff, as_sat_in;
   logic [64:0]        mix_re, mix_im, abs_re, abs_im;

   always_comb begin
      case (prod_kind_ff)
         KIND_MUL: begin
            mix_re = {p_rr_ff[63], p_rr_ff} - {p_ii_ff[63], p_ii_ff};
            mix_im = {p_ri_ff[63], p_ri_ff} + {p_ir_ff[63], p_ir_ff};
         end
         default: begin
            mix_re = {p_rr_ff[63], p_rr_ff} + {p_ii_ff[63], p_ii_ff};
            mix_im = {p_ir_ff[63], p_ir_ff} - {p_ri_ff[63], p_ri_ff};
         end
      endcase
      abs_re    = mix_re[64] ? -mix_re : mix_re;
      abs_im    = mix_im[64] ? -mix_im : mix_im;
      re_neg_in = mix_re[64];
      im_neg_in = mix_im[64];
      re_mag_in = abs_re[63:0];
      im_mag_in = abs_im[63:0];
      den_in    = p_bb_ff + p_cc_ff;
      as_sat_in    = (as_re_ff[32] != as_re_ff[31]) || (as_im_ff[32] != as_im_ff[31]);
      as_re_sat_in = as_re_ff[31:0];
      as_im_sat_in = as_im_ff[31:0];
      if (as_re_ff[32] != as_re_ff[31]) begin
         as_re_sat_in = as_re_ff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (as_im_ff[32] != as_im_ff[31]) begin
         as_im_sat_in = as_im_ff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
   end

   // early results, then hold them across the divider and the modulus root
   side_type    side1_in;
   cau_fix_type mul_re_fix, mul_im_fix;

   always_comb begin
      mul_re_fix = to_fixed(re_neg_ff, (re_mag_ff + ROUND_HALF) >> FRAC_BITS);
      mul_im_fix = to_fixed(im_neg_ff, (im_mag_ff + ROUND_HALF) >> FRAC_BITS);
      side1_in          = '0;
      side1_in.kind     = sum_kind_ff;
      side1_in.re_neg   = re_neg_ff;
      side1_in.im_neg   = im_neg_ff;
      side1_in.a_real   = sum_ar_ff;
      side1_in.a_neg    = sum_ai_ff[31];
      case (sum_kind_ff)
         KIND_ADD, KIND_SUB: begin
            side1_in.res_real = as_re_sat_ff;
            side1_in.res_imag = as_im_sat_ff;
            side1_in.sat      = as_sat_ff;
         end
         KIND_MUL: begin
            side1_in.res_real = mul_re_fix.value;
            side1_in.res_imag = mul_im_fix.value;
            side1_in.sat      = mul_re_fix.sat || mul_im_fix.sat;
         end
         KIND_DIV: begin
            side1_in.dz = den_ff == 64'd0;
         end
         default: begin
            side1_in.sat = 1'b0;
         end
      endcase
   end

   logic     line1_valid_ff [0:ISQRT_LAT-1];
   side_type line1_ff       [0:ISQRT_LAT-1];

   logic                 div_re_valid, div_im_valid;
   logic [DIV_QBITS-1:0] div_re_quot, div_im_quot;
   logic                 div_re_ovf, div_im_ovf;
   logic                 root_valid;
   logic [32:0]          root;

   cau_div u_div_re (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid_ff),
      .in_num    (re_mag_ff),
      .in_den    (den_ff),
      .out_valid (div_re_valid),
      .out_quot  (div_re_quot),
      .out_ovf   (div_re_ovf)
   );

   cau_div u_div_im (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid_ff),
      .in_num    (im_mag_ff),
      .in_den    (den_ff),
      .out_valid (div_im_valid),
      .out_quot  (div_im_quot),
      .out_ovf   (div_im_ovf)
   );

   cau_isqrt u_modulus (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sum_valid_ff),
      .in_radicand (den_ff),
      .out_valid   (root_valid),
      .out_root    (root)
   );

   // merge divider and modulus results, and form the radicands for the root parts
   side_type             side1_out;
   side_type             side2_in;
   logic [DIV_QBITS:0]   q_re_inc, q_im_inc;
   logic [63:0]          div_re_mag, div_im_mag;
   cau_fix_type          div_re_fix, div_im_fix, mod_fix;
   logic [33:0]          sq_re_sum, sq_im_sum;
   logic [63:0]          sq_re_rad, sq_im_rad;

   always_comb begin
      side1_out  = line1_ff[ISQRT_LAT-1];
      q_re_inc   = {1'b0, div_re_quot} + 1'b1;
      q_im_inc   = {1'b0, div_im_quot} + 1'b1;
      div_re_mag = div_re_ovf ? DIV_BIG : 64'(q_re_inc[DIV_QBITS:1]);
      div_im_mag = div_im_ovf ? DIV_BIG : 64'(q_im_inc[DIV_QBITS:1]);
      div_re_fix = to_fixed(side1_out.re_neg, div_re_mag);
      div_im_fix = to_fixed(side1_out.im_neg, div_im_mag);
      mod_fix    = to_fixed(1'b0, 64'(root));
      side2_in   = side1_out;
      case (side1_out.kind)
         KIND_DIV: begin
            if (!side1_out.dz) begin
               side2_in.res_real = div_re_fix.value;
               side2_in.res_imag = div_im_fix.value;
               side2_in.sat      = div_re_fix.sat || div_im_fix.sat;
            end
         end
         KIND_MOD: begin
            side2_in.res_real = mod_fix.value;
            side2_in.res_imag = '0;
            side2_in.sat      = mod_fix.sat;
         end
         default: begin
            side2_in.dz = side1_out.dz;
         end
      endcase
      sq_re_sum = {1'b0, root} + {{2{side1_out.a_real[31]}}, side1_out.a_real};
      sq_im_sum = {1'b0, root} - {{2{side1_out.a_real[31]}}, side1_out.a_real};
      sq_re_rad = 64'(sq_re_sum) << (FRAC_BITS - 1);
      sq_im_rad = 64'(sq_im_sum) << (FRAC_BITS - 1);
   end

   logic        sq_re_valid, sq_im_valid;
   logic [32:0] sq_re_root, sq_im_root;

   cau_isqrt u_root_re (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (line1_valid_ff[ISQRT_LAT-1]),
      .in_radicand (sq_re_rad),
      .out_valid   (sq_re_valid),
      .out_root    (sq_re_root)
   );

   cau_isqrt u_root_im (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (line1_valid_ff[ISQRT_LAT-1]),
      .in_radicand (sq_im_rad),
      .out_valid   (sq_im_valid),
      .out_root    (sq_im_root)
   );

   logic     line2_valid_ff [0:ISQRT_LAT-1];
   side_type line2_ff       [0:ISQRT_LAT-1];

   // result stage
   side_type    side2_out;
   logic        rsp_strobe_ff;
   cau_rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      side2_out            = line2_ff[ISQRT_LAT-1];
      rsp_data_in.res_real = side2_out.res_real;
      rsp_data_in.res_imag = side2_out.res_imag;
      if (side2_out.dz) begin
         rsp_data_in.status = STATUS_DIV_ZERO;
      end else if (side2_out.sat) begin
         rsp_data_in.status = STATUS_SAT;
      end else begin
         rsp_data_in.status = STATUS_OK;
      end
      if (side2_out.kind == KIND_SQRT) begin
         rsp_data_in.res_real = sq_re_root[31:0];
         rsp_data_in.res_imag = side2_out.a_neg ? ~sq_im_root[31:0] + 32'd1
                                                : sq_im_root[31:0];
         rsp_data_in.status   = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         for (int i = 0; i < ISQRT_LAT; i++) begin
            line1_valid_ff[i] <= 1'b0;
            line2_valid_ff[i] <= 1'b0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         op_valid_ff       <= start && !busy;
         prod_valid_ff     <= op_valid_ff;
         sum_valid_ff      <= prod_valid_ff;
         line1_valid_ff[0] <= sum_valid_ff;
         line2_valid_ff[0] <= line1_valid_ff[ISQRT_LAT-1];
         for (int i = 1; i < ISQRT_LAT; i++) begin
            line1_valid_ff[i] <= line1_valid_ff[i-1];
            line2_valid_ff[i] <= line2_valid_ff[i-1];
         end
         rsp_strobe_ff <= line2_valid_ff[ISQRT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      prod_kind_ff <= op_ff.kind;
      prod_ar_ff   <= op_ff.a_real;
      prod_ai_ff   <= op_ff.a_imag;
      p_rr_ff      <= p_rr_in;
      p_ii_ff      <= p_ii_in;
      p_ri_ff      <= p_ri_in;
      p_ir_ff      <= p_ir_in;
      p_bb_ff      <= p_bb_in;
      p_cc_ff      <= p_cc_in;
      as_re_ff     <= as_re_in;
      as_im_ff     <= as_im_in;
      sum_kind_ff  <= prod_kind_ff;
      sum_ar_ff    <= prod_ar_ff;
      sum_ai_ff    <= prod_ai_ff;
      re_neg_ff    <= re_neg_in;
      im_neg_ff    <= im_neg_in;
      re_mag_ff    <= re_mag_in;
      im_mag_ff    <= im_mag_in;
      den_ff       <= den_in;
      as_re_sat_ff <= as_re_sat_in;
      as_im_sat_ff <= as_im_sat_in;
      as_sat_ff    <= as_sat_in;
      line1_ff[0]  <= side1_in;
      line2_ff[0]  <= side2_in;
      for (int i = 1; i < ISQRT_LAT; i++) begin
         line1_ff[i] <= line1_ff[i-1];
         line2_ff[i] <= line2_ff[i-1];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `CAU_ASSERT_IMPLY(a_rsp_origin, rsp_strobe, $past(start && !busy, RSP_LATENCY),
      "result strobe without a transaction at the input")
   `CAU_ASSERT_SAME(a_div_align, line1_valid_ff[ISQRT_LAT-1], div_re_valid && div_im_valid,
      "divider out of step with the side line")
   `CAU_ASSERT_SAME(a_mod_align, line1_valid_ff[ISQRT_LAT-1], root_valid,
      "modulus root out of step with the side line")
   `CAU_ASSERT_SAME(a_sqrt_align, line2_valid_ff[ISQRT_LAT-1], sq_re_valid && sq_im_valid,
      "root parts out of step with the side line")

endmodule
